/* src/dnsa_pkg.sv */
// Package for the DNS answer A-record extractor.
// Holds the parse phase type, result struct and protocol constants.
// No dependencies.
`timescale 1ns / 1ps

package dnsa_pkg;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_NAME   = 3'd1,
        PH_LABEL  = 3'd2,
        PH_PTR    = 3'd3,
        PH_QTAIL  = 3'd4,
        PH_FIXED  = 3'd5,
        PH_RDATA  = 3'd6,
        PH_ADDR   = 3'd7
    } t_phase;

    typedef struct packed {
        logic        found;
        logic [31:0] address;
    } t_result;

    // outcome flag bit positions
    localparam int FLAG_FOUND  = 0;
    localparam int FLAG_FAILED = 1;

    // header byte positions
    localparam logic [3:0] HDR_FLAGS_IDX = 4'd2;
    localparam logic [3:0] HDR_QD_HI_IDX = 4'd4;
    localparam logic [3:0] HDR_QD_LO_IDX = 4'd5;
    localparam logic [3:0] HDR_AN_HI_IDX = 4'd6;
    localparam logic [3:0] HDR_AN_LO_IDX = 4'd7;
    localparam logic [3:0] HDR_LAST_IDX  = 4'd11;

    // answer fixed-field byte positions
    localparam logic [3:0] FIX_TYPE_HI_IDX = 4'd0;
    localparam logic [3:0] FIX_TYPE_LO_IDX = 4'd1;
    localparam logic [3:0] FIX_LEN_HI_IDX  = 4'd8;
    localparam logic [3:0] FIX_LEN_LO_IDX  = 4'd9;

    localparam logic [3:0] ADDR_LAST_IDX = 4'd3;

    localparam logic [7:0]  RESP_BIT_MASK = 8'h80;
    localparam logic [7:0]  LABEL_TYPE_MASK = 8'hC0;
    localparam logic [15:0] QTAIL_LEN = 16'd4;
    localparam logic [15:0] TYPE_A = 16'd1;
    localparam logic [15:0] A_DATA_LEN = 16'd4;

endpackage

/* src/dnsa_parse.sv */
// Byte-wise DNS response parser state and next-state logic.
// Depends on dnsa_pkg.
`timescale 1ns / 1ps

module dnsa_parse
    import dnsa_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,     // consume one byte this cycle
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output t_result    o_result    // valid with i_step && i_last
);

    t_phase      r_phase, n_phase;
    logic [3:0]  r_idx, n_idx;
    logic [15:0] r_qd, n_qd;
    logic [15:0] r_an, n_an;
    logic [15:0] r_skip, n_skip;
    logic [15:0] r_type, n_type;
    logic [15:0] r_len, n_len;
    logic [31:0] r_addr, n_addr;
    logic [1:0]  r_flags, n_flags;

    always_comb begin
        n_phase = r_phase;
        n_idx   = r_idx;
        n_qd    = r_qd;
        n_an    = r_an;
        n_skip  = r_skip;
        n_type  = r_type;
        n_len   = r_len;
        n_addr  = r_addr;
        n_flags = r_flags;

        if (r_flags == 2'b00) begin
            case (r_phase)
                PH_HEADER: begin
                    if (r_idx == HDR_FLAGS_IDX && (i_byte & RESP_BIT_MASK) == 8'h00) begin
                        n_flags[FLAG_FAILED] = 1'b1;
                    end else if (r_idx == HDR_QD_HI_IDX) begin
                        n_qd = {i_byte, 8'h00};
                    end else if (r_idx == HDR_QD_LO_IDX) begin
                        n_qd = n_qd | {8'h00, i_byte};
                    end else if (r_idx == HDR_AN_HI_IDX) begin
                        n_an = {i_byte, 8'h00};
                    end else if (r_idx == HDR_AN_LO_IDX) begin
                        n_an = n_an | {8'h00, i_byte};
                    end
                    if (r_idx >= HDR_LAST_IDX) begin
                        n_idx = 4'd0;
                        if (n_flags == 2'b00) begin
                            if (n_qd != 16'd0 || n_an != 16'd0) begin
                                n_phase = PH_NAME;
                            end else begin
                                n_flags[FLAG_FAILED] = 1'b1;
                            end
                        end
                    end else begin
                        n_idx = r_idx + 4'd1;
                    end
                end
                PH_NAME: begin
                    if ((i_byte & LABEL_TYPE_MASK) != 8'h00) begin
                        n_phase = PH_PTR;
                    end else if (i_byte == 8'h00) begin
                        if (n_qd != 16'd0) begin
                            n_phase = PH_QTAIL;
                            n_skip  = QTAIL_LEN;
                        end else begin
                            n_phase = PH_FIXED;
                            n_idx   = 4'd0;
                            n_type  = 16'd0;
                            n_len   = 16'd0;
                        end
                    end else begin
                        n_phase = PH_LABEL;
                        n_skip  = {8'h00, i_byte};
                    end
                end
                PH_LABEL: begin
                    n_skip = r_skip - 16'd1;
                    if (n_skip == 16'd0) begin
                        n_phase = PH_NAME;
                    end
                end
                PH_PTR: begin
                    if (n_qd != 16'd0) begin
                        n_phase = PH_QTAIL;
                        n_skip  = QTAIL_LEN;
                    end else begin
                        n_phase = PH_FIXED;
                        n_idx   = 4'd0;
                        n_type  = 16'd0;
                        n_len   = 16'd0;
                    end
                end
                PH_QTAIL: begin
                    n_skip = r_skip - 16'd1;
                    if (n_skip == 16'd0) begin
                        n_qd = r_qd - 16'd1;
                        if (n_qd != 16'd0 || n_an != 16'd0) begin
                            n_phase = PH_NAME;
                        end else begin
                            n_flags[FLAG_FAILED] = 1'b1;
                        end
                    end
                end
                PH_FIXED: begin
                    if (r_idx == FIX_TYPE_HI_IDX) begin
                        n_type = {i_byte, 8'h00};
                    end else if (r_idx == FIX_TYPE_LO_IDX) begin
                        n_type = n_type | {8'h00, i_byte};
                    end else if (r_idx == FIX_LEN_HI_IDX) begin
                        n_len = {i_byte, 8'h00};
                    end else if (r_idx == FIX_LEN_LO_IDX) begin
                        n_len = n_len | {8'h00, i_byte};
                    end
                    if (r_idx >= FIX_LEN_LO_IDX) begin
                        n_idx = 4'd0;
                        if (n_type == TYPE_A && n_len == A_DATA_LEN) begin
                            n_phase = PH_ADDR;
                            n_addr  = 32'd0;
                        end else if (n_len == 16'd0) begin
                            n_an = r_an - 16'd1;
                            if (n_qd != 16'd0 || n_an != 16'd0) begin
                                n_phase = PH_NAME;
                            end else begin
                                n_flags[FLAG_FAILED] = 1'b1;
                            end
                        end else begin
                            n_phase = PH_RDATA;
                            n_skip  = n_len;
                        end
                    end else begin
                        n_idx = r_idx + 4'd1;
                    end
                end
                PH_RDATA: begin
                    n_skip = r_skip - 16'd1;
                    if (n_skip == 16'd0) begin
                        n_an = r_an - 16'd1;
                        if (n_qd != 16'd0 || n_an != 16'd0) begin
                            n_phase = PH_NAME;
                        end else begin
                            n_flags[FLAG_FAILED] = 1'b1;
                        end
                    end
                end
                PH_ADDR: begin
                    n_addr = {r_addr[23:0], i_byte};
                    if (r_idx >= ADDR_LAST_IDX) begin
                        n_idx = 4'd0;
                        n_flags[FLAG_FOUND] = 1'b1;
                    end else begin
                        n_idx = r_idx + 4'd1;
                    end
                end
                default: begin
                    n_phase = PH_HEADER;
                end
            endcase
        end

        // result reflects this byte's update; address zero when not found
        o_result.found   = n_flags[FLAG_FOUND];
        o_result.address = n_flags[FLAG_FOUND] ? n_addr : 32'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_phase <= PH_HEADER;
            r_idx   <= 4'd0;
            r_qd    <= 16'd0;
            r_an    <= 16'd0;
            r_skip  <= 16'd0;
            r_type  <= 16'd0;
            r_len   <= 16'd0;
            r_addr  <= 32'd0;
            r_flags <= 2'b00;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_qd    <= n_qd;
            r_an    <= n_an;
            r_skip  <= n_skip;
            r_type  <= n_type;
            r_len   <= n_len;
            r_addr  <= n_addr;
            r_flags <= n_flags;
        end
    end

endmodule

/* src/dns_answer_a_record_extractor.sv */
// Top level of the DNS answer A-record extractor: input register, parser, result register.
// Depends on dnsa_pkg and dnsa_parse.
`timescale 1ns / 1ps

// Usage
//   Slave stream: one DNS response byte per transaction on s_axis_tdata, with
//   s_axis_tlast high on the final byte of the packet.
//   Master stream: exactly one transaction per packet, after its final byte.
//   m_axis_tuser is the found flag, m_axis_tdata the IPv4 address (first
//   address byte in the top bits), zero when nothing was found.
//   A packet is not found when the header's response bit is clear, when the
//   question and answer counts run out without a type-A, 4-byte answer, or
//   when the packet ends before the address bytes are all in.
// Throughput: one byte per cycle, except while a final byte waits (see Stall). The byte path is a registered
//   input stage feeding the parser, whose per-byte update is a few counter
//   decrements and compares, then the result register.
// Result path: the last byte is registered in the input stage, then its result in the result register.
// Stall: while a result waits in the output register, non-final bytes keep
//   flowing; only a final byte waits in the input register, which then holds
//   s_axis_tready low until the result is taken.
// Reset: synchronous, active low; clears the valid flags of both registers and the parser,
//   which starts over expecting a header.

module dns_answer_a_record_extractor
    import dnsa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // last_byte

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] address
    output logic        m_axis_tuser    // [0] found
);

    // input stage
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // result stage
    logic       r_out_valid;
    t_result    r_out;

    logic       out_free;
    logic       step;
    t_result    parse_result;

    // a final byte needs a free result register; others always proceed
    assign out_free = !r_out_valid || m_axis_tready;
    assign step     = r_in_valid && (!r_in_last || out_free);

    assign s_axis_tready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    dnsa_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .o_result (parse_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && r_in_last) begin
            r_out <= parse_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out.address;
    assign m_axis_tuser  = r_out.found;

endmodule
